### rtl/core/motor_feedback_multiturn_tracker_core_macros.svh
// Assertion macros for the multiturn tracker core.
`ifndef MOTOR_FEEDBACK_MULTITURN_TRACKER_CORE_MACROS_SVH
`define MOTOR_FEEDBACK_MULTITURN_TRACKER_CORE_MACROS_SVH

// same-cycle implication
`define MFTC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MFTC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/mftc_pkg.sv
package mftc_pkg;

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   localparam logic REG_ANGLE_SCALE = 1'b0;
   localparam logic REG_SPEED_SCALE = 1'b1;

   localparam logic [31:0] ANGLE_SCALE_RST = 32'd171545;
   localparam logic [31:0] SPEED_SCALE_RST = 32'd23421000;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   localparam logic signed [53:0] SAT_MAX = 54'sd2147483647;
   localparam logic signed [53:0] SAT_MIN = -54'sd2147483648;

   typedef struct packed {
      logic               link;
      logic signed [23:0] turns;
      logic [12:0]        position;
      logic signed [15:0] speed;
      logic signed [15:0] current;
      logic [7:0]         temperature;
   } mftc_snap_type;

   typedef struct packed {
      logic full;
      logic empty;
   } mftc_fifo_stat_type;

   function automatic logic signed [31:0] mftc_sat32(input logic signed [53:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### rtl/core/mftc_chan_if.sv
interface mftc_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [12:0]        encoder_position;
   logic signed [15:0] speed_rpm;
   logic signed [15:0] current_raw;
   logic [7:0]         temperature_raw;

   modport source (output valid, kind, encoder_position, speed_rpm, current_raw,
                   temperature_raw, input ready);
   modport sink (input valid, kind, encoder_position, speed_rpm, current_raw,
                 temperature_raw, output ready);
endinterface

interface mftc_rsp_if;
   logic               valid;
   logic               ready;
   logic               link_up;
   logic signed [23:0] turn_count;
   logic signed [36:0] total_position;
   logic signed [31:0] angle_q16;
   logic signed [31:0] omega_q16;
   logic signed [15:0] current_out;
   logic [7:0]         temperature_out;

   modport source (output valid, link_up, turn_count, total_position, angle_q16,
                   omega_q16, current_out, temperature_out, input ready);
   modport sink (input valid, link_up, turn_count, total_position, angle_q16,
                 omega_q16, current_out, temperature_out, output ready);
endinterface

### rtl/core/motor_feedback_multiturn_tracker_core.sv
// Multi-turn tracker for an absolute single-turn encoder. Each request word is
// either a feedback frame or an alive tick and yields exactly one response word
// with link state, turn count, total position, output-shaft angle and speed in
// saturated Q16.16, and the latest current and temperature. Throughput is one
// word per clock while the queue has room and responses are taken. The front,
// which updates the turn and link state, writes a four-entry queue; three
// back-end stages follow, set by splitting the 37 x 32 bit angle product into
// two partial products before the rounding add. The user must write scale
// registers via the csr port only while no word is in flight (not enforced).
`include "motor_feedback_multiturn_tracker_core_macros.svh"

module motor_feedback_multiturn_tracker_core
   import mftc_pkg::*;
#(
   parameter int COUNTS_PER_TURN = 8192
) (
   input  logic        clock,
   input  logic        reset,
   mftc_req_if.sink    req_ch,
   mftc_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   logic               push;
   logic               pop;
   mftc_snap_type      push_data;
   mftc_snap_type      pop_data;
   mftc_fifo_stat_type fifo_stat;
   logic [31:0]        angle_scale_ff;
   logic [31:0]        speed_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_scale_ff <= ANGLE_SCALE_RST;
         speed_scale_ff <= SPEED_SCALE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ANGLE_SCALE: angle_scale_ff <= csr_wdata;
            REG_SPEED_SCALE: speed_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   mftc_front #(
      .COUNTS_PER_TURN(COUNTS_PER_TURN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .fifo_stat (fifo_stat),
      .push      (push),
      .push_data (push_data)
   );

   mftc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (fifo_stat)
   );

   mftc_back #(
      .COUNTS_PER_TURN(COUNTS_PER_TURN)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (!fifo_stat.empty),
      .in_data     (pop_data),
      .pop         (pop),
      .angle_scale (angle_scale_ff),
      .speed_scale (speed_scale_ff),
      .rsp_ch      (rsp_ch)
   );

   `MFTC_ASSERT_IMP(a_no_overflow, push, !fifo_stat.full, "queue push while full")
   `MFTC_ASSERT_IMP(a_no_underflow, pop, !fifo_stat.empty, "queue pop while empty")
   `MFTC_ASSERT_NXT(a_push_lands, push, !fifo_stat.empty, "queue empty after push")

endmodule

### rtl/core/mftc_front.sv
module mftc_front
   import mftc_pkg::*;
#(
   parameter int COUNTS_PER_TURN = 8192
) (
   input  logic               clock,
   input  logic               reset,
   mftc_req_if.sink           req_ch,
   input  mftc_fifo_stat_type fifo_stat,
   output logic               push,
   output mftc_snap_type      push_data
);

   localparam logic signed [17:0] HALF = 18'(COUNTS_PER_TURN / 2);

   logic [12:0]        last_pos_ff, last_pos_in;
   logic signed [23:0] turns_ff, turns_in;
   logic               seen_ff, seen_in;
   logic               link_ff, link_in;
   logic signed [15:0] speed_ff, speed_in;
   logic signed [15:0] current_ff, current_in;
   logic [7:0]         temp_ff, temp_in;
   logic signed [17:0] delta;

   assign req_ch.ready = !fifo_stat.full;
   assign push = req_ch.valid && !fifo_stat.full;
   assign delta = $signed({5'b0, req_ch.encoder_position}) - $signed({5'b0, last_pos_ff});

   always_comb begin
      last_pos_in = last_pos_ff;
      turns_in    = turns_ff;
      seen_in     = seen_ff;
      link_in     = link_ff;
      speed_in    = speed_ff;
      current_in  = current_ff;
      temp_in     = temp_ff;
      if (push) begin
         if (req_ch.kind == KIND_FRAME) begin
            if (delta < -HALF) begin
               turns_in = turns_ff + 24'sd1;
            end else if (delta > HALF) begin
               turns_in = turns_ff - 24'sd1;
            end
            last_pos_in = req_ch.encoder_position;
            speed_in    = req_ch.speed_rpm;
            current_in  = req_ch.current_raw;
            temp_in     = req_ch.temperature_raw;
            seen_in     = 1'b1;
         end else begin
            link_in = seen_ff;
            seen_in = 1'b0;
         end
      end
   end

   assign push_data = '{link: link_in, turns: turns_in, position: last_pos_in,
                        speed: speed_in, current: current_in, temperature: temp_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pos_ff <= '0;
         turns_ff    <= '0;
         seen_ff     <= 1'b0;
         link_ff     <= 1'b0;
         speed_ff    <= '0;
         current_ff  <= '0;
         temp_ff     <= '0;
      end else begin
         last_pos_ff <= last_pos_in;
         turns_ff    <= turns_in;
         seen_ff     <= seen_in;
         link_ff     <= link_in;
         speed_ff    <= speed_in;
         current_ff  <= current_in;
         temp_ff     <= temp_in;
      end
   end

endmodule

### rtl/core/mftc_fifo.sv
module mftc_fifo
   import mftc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mftc_snap_type      push_data,
   input  logic               pop,
   output mftc_snap_type      pop_data,
   output mftc_fifo_stat_type stat
);

   mftc_snap_type        mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;

   assign stat.full  = (count_ff == (FIFO_AW + 1)'(FIFO_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/mftc_back.sv
module mftc_back
   import mftc_pkg::*;
#(
   parameter int COUNTS_PER_TURN = 8192
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  mftc_snap_type in_data,
   output logic          pop,
   input  logic [31:0]   angle_scale,
   input  logic [31:0]   speed_scale,
   mftc_rsp_if.source    rsp_ch
);

   localparam logic signed [17:0] CPT = 18'(COUNTS_PER_TURN);

   logic adv;

   // stage 1: total position
   logic               s1_valid_ff;
   logic signed [41:0] turn_prod;
   logic signed [36:0] s1_total_ff, s1_total_in;
   mftc_snap_type      s1_snap_ff;

   // stage 2: partial products
   logic               s2_valid_ff;
   logic signed [53:0] s2_ph_ff, s2_ph_in;
   logic [47:0]        s2_pl_ff, s2_pl_in;
   logic signed [48:0] s2_ps_ff, s2_ps_in;
   logic signed [36:0] s2_total_ff;
   mftc_snap_type      s2_snap_ff;

   // stage 3: round, saturate, result word
   logic               out_valid_ff;
   logic signed [69:0] angle_sum;
   logic signed [49:0] speed_sum;
   logic signed [31:0] angle_ff, angle_in;
   logic signed [31:0] omega_ff, omega_in;
   logic signed [36:0] out_total_ff;
   mftc_snap_type      out_snap_ff;

   assign adv = !out_valid_ff || rsp_ch.ready;
   assign pop = adv && in_valid;

   assign turn_prod   = $signed(in_data.turns) * CPT;
   assign s1_total_in = turn_prod[36:0] + $signed({24'b0, in_data.position});

   assign s2_ph_in = $signed(s1_total_ff[36:16]) * $signed({1'b0, angle_scale});
   assign s2_pl_in = s1_total_ff[15:0] * angle_scale;
   assign s2_ps_in = s1_snap_ff.speed * $signed({1'b0, speed_scale});

   assign angle_sum = $signed({s2_ph_ff, 16'h0000}) + $signed({22'b0, s2_pl_ff})
                      + 70'sd32768;
   assign speed_sum = $signed({s2_ps_ff[48], s2_ps_ff}) + 50'sd32768;
   assign angle_in  = mftc_sat32(angle_sum[69:16]);
   assign omega_in  = mftc_sat32($signed({{20{speed_sum[49]}}, speed_sum[49:16]}));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_total_ff  <= s1_total_in;
         s1_snap_ff   <= in_data;
         s2_ph_ff     <= s2_ph_in;
         s2_pl_ff     <= s2_pl_in;
         s2_ps_ff     <= s2_ps_in;
         s2_total_ff  <= s1_total_ff;
         s2_snap_ff   <= s1_snap_ff;
         angle_ff     <= angle_in;
         omega_ff     <= omega_in;
         out_total_ff <= s2_total_ff;
         out_snap_ff  <= s2_snap_ff;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.link_up         = out_snap_ff.link;
   assign rsp_ch.turn_count      = out_snap_ff.turns;
   assign rsp_ch.total_position  = out_total_ff;
   assign rsp_ch.angle_q16       = angle_ff;
   assign rsp_ch.omega_q16       = omega_ff;
   assign rsp_ch.current_out     = out_snap_ff.current;
   assign rsp_ch.temperature_out = out_snap_ff.temperature;

endmodule

### verif/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mftc_pkg::*;

   localparam int COUNTS_PER_TURN = 8192;
   localparam int HALF_TURN       = COUNTS_PER_TURN / 2;
   localparam int PHASES          = 7;
   localparam int WORDS_PER_PHASE = 165;
   localparam int HOLD_AFTER      = 400;
   localparam int HOLD_CYCLES     = 96;

   typedef struct packed {
      logic               kind;
      logic [12:0]        position;
      logic signed [15:0] speed;
      logic signed [15:0] current;
      logic [7:0]         temperature;
   } motor_word_type;

   typedef struct packed {
      logic               link;
      logic signed [23:0] turns;
      logic signed [36:0] total;
      logic signed [31:0] angle;
      logic signed [31:0] omega;
      logic signed [15:0] current;
      logic [7:0]         temperature;
   } feedback_type;

   class tracker_scoreboard;
      logic [31:0]        angle_scale = ANGLE_SCALE_RST;
      logic [31:0]        speed_scale = SPEED_SCALE_RST;
      logic [12:0]        last_position = '0;
      logic signed [23:0] turns = '0;
      logic               frame_seen = 1'b0;
      logic               link_state = 1'b0;
      logic signed [15:0] last_speed = '0;
      logic signed [15:0] last_current = '0;
      logic [7:0]         last_temperature = '0;
      feedback_type       expected_q[$];
      int                 errors;
      int                 checked;
      int                 frames;
      int                 ticks;
      int                 turn_events;
      int                 saturated;

      function void set_scale(logic idx, logic [31:0] value);
         if (idx == REG_ANGLE_SCALE) begin
            angle_scale = value;
         end else begin
            speed_scale = value;
         end
      endfunction

      // round half up of x * scale / 2^16, clamped to int32
      function logic signed [31:0] scaled_q16(logic signed [36:0] x, logic [31:0] scale);
         logic signed [71:0] xw;
         logic signed [71:0] sw;
         logic signed [71:0] r;
         xw = x;
         sw = {40'd0, scale};
         r = (xw * sw + 72'sd32768) >>> 16;
         if (r > 72'sd2147483647) begin
            saturated++;
            return 32'sh7FFFFFFF;
         end
         if (r < -72'sd2147483648) begin
            saturated++;
            return 32'sh80000000;
         end
         return r[31:0];
      endfunction

      function void note_word(motor_word_type w);
         int           delta;
         longint       span;
         feedback_type e;
         if (w.kind == KIND_FRAME) begin
            delta = int'(w.position) - int'(last_position);
            if (delta < -HALF_TURN) begin
               turns = turns + 24'sd1;
               turn_events++;
            end else if (delta > HALF_TURN) begin
               turns = turns - 24'sd1;
               turn_events++;
            end
            last_position    = w.position;
            last_speed       = w.speed;
            last_current     = w.current;
            last_temperature = w.temperature;
            frame_seen       = 1'b1;
            frames++;
         end else begin
            link_state = frame_seen;
            frame_seen = 1'b0;
            ticks++;
         end
         span = longint'(turns) * COUNTS_PER_TURN + longint'(last_position);
         e.link        = link_state;
         e.turns       = turns;
         e.total       = span[36:0];
         e.angle       = scaled_q16(e.total, angle_scale);
         e.omega       = scaled_q16(last_speed, speed_scale);
         e.current     = last_current;
         e.temperature = last_temperature;
         expected_q.push_back(e);
      endfunction

      function void compare(string field, longint e, longint a);
         if (e != a) begin
            errors++;
            if (errors <= 200) begin
               $display("%0t: %s expected %0d, got %0d", $time, field, e, a);
            end
         end
      endfunction

      function void check_word(feedback_type got);
         feedback_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: response expected none, got turns %0d total %0d",
                     $time, got.turns, got.total);
            return;
         end
         e = expected_q.pop_front();
         checked++;
         compare("link_up", e.link, got.link);
         compare("turn_count", e.turns, got.turns);
         compare("total_position", e.total, got.total);
         compare("angle_q16", e.angle, got.angle);
         compare("omega_q16", e.omega, got.omega);
         compare("current_out", e.current, got.current);
         compare("temperature_out", e.temperature, got.temperature);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   logic        csr_index;
   logic [31:0] csr_wdata;

   mftc_req_if req_ch();
   mftc_rsp_if rsp_ch();

   tracker_scoreboard sb = new;

   logic [12:0] drive_pos = '0;
   int          spin_dir = 1;
   int          burst_left = 0;
   bit          long_hold_done = 1'b0;

   motor_feedback_multiturn_tracker_core #(
      .COUNTS_PER_TURN(COUNTS_PER_TURN)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      motor_word_type w;
      feedback_type   f;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            w.kind        = req_ch.kind;
            w.position    = req_ch.encoder_position;
            w.speed       = req_ch.speed_rpm;
            w.current     = req_ch.current_raw;
            w.temperature = req_ch.temperature_raw;
            sb.note_word(w);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            f.link        = rsp_ch.link_up;
            f.turns       = rsp_ch.turn_count;
            f.total       = rsp_ch.total_position;
            f.angle       = rsp_ch.angle_q16;
            f.omega       = rsp_ch.omega_q16;
            f.current     = rsp_ch.current_out;
            f.temperature = rsp_ch.temperature_out;
            sb.check_word(f);
         end
      end
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // response side: random stalls, one long hold to back the block up
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(40, 120)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         stall = idle_len();
         if (!long_hold_done && sb.checked >= HOLD_AFTER) begin
            stall = HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   function automatic motor_word_type frame_word(int pos, int spd, int cur, int tmp);
      motor_word_type w;
      w.kind        = KIND_FRAME;
      w.position    = 13'(pos);
      w.speed       = 16'(spd);
      w.current     = 16'(cur);
      w.temperature = 8'(tmp);
      return w;
   endfunction

   function automatic motor_word_type tick_word();
      motor_word_type w;
      w.kind        = KIND_TICK;
      w.position    = 13'($urandom);
      w.speed       = 16'($urandom);
      w.current     = 16'($urandom);
      w.temperature = 8'($urandom);
      return w;
   endfunction

   // mostly steady rotation so turns accumulate; some half-turn probes and noise
   function automatic motor_word_type random_word();
      motor_word_type w;
      int             r;
      int             step;
      w = tick_word();
      if ($urandom_range(0, 99) < 12) return w;
      w.kind = KIND_FRAME;
      if ($urandom_range(0, 19) == 0) spin_dir = -spin_dir;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         step = spin_dir * int'($urandom_range(200, 3500));
      end else if (r < 75) begin
         step = int'($urandom_range(HALF_TURN - 1, HALF_TURN + 1));
         if ($urandom_range(0, 1) == 0) step = -step;
      end else if (r < 88) begin
         step = int'($urandom_range(0, 40)) - 20;
      end else begin
         step = int'($urandom_range(0, COUNTS_PER_TURN - 1));
      end
      w.position = 13'(int'(drive_pos) + step);
      case ($urandom_range(0, 9))
         0: w.speed = 16'sh7FFF;
         1: w.speed = 16'sh8000;
         2: w.speed = $urandom_range(0, 1) ? 16'sh0000 : 16'shFFFF;
         3, 4, 5: w.speed = 16'(int'($urandom_range(0, 1000)) - 500);
         default: w.speed = 16'($urandom);
      endcase
      return w;
   endfunction

   task automatic send_word(input motor_word_type w);
      req_ch.valid            <= 1'b1;
      req_ch.kind             <= w.kind;
      req_ch.encoder_position <= w.position;
      req_ch.speed_rpm        <= w.speed;
      req_ch.current_raw      <= w.current;
      req_ch.temperature_raw  <= w.temperature;
      if (w.kind == KIND_FRAME) drive_pos = w.position;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         gap = idle_len();
         if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_scale(input logic idx, input logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_scale(idx, value);
   endtask

   initial begin
      motor_word_type seq[$];
      logic [31:0]    angle_val;
      logic [31:0]    speed_val;
      req_ch.valid            = 1'b0;
      req_ch.kind             = KIND_FRAME;
      req_ch.encoder_position = '0;
      req_ch.speed_rpm        = '0;
      req_ch.current_raw      = '0;
      req_ch.temperature_raw  = '0;
      csr_we                  = 1'b0;
      csr_index               = REG_ANGLE_SCALE;
      csr_wdata               = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // link down before any frame, first frame above half a turn,
      // jumps of exactly half a turn and one past it, field extremes
      seq.push_back(tick_word());
      seq.push_back(frame_word(8191, 32767, -32768, 255));
      seq.push_back(frame_word(4095, -32768, 32767, 0));
      seq.push_back(frame_word(0, 0, 0, 1));
      seq.push_back(frame_word(4096, -1, -1, 128));
      seq.push_back(frame_word(0, 1, 1, 127));
      seq.push_back(frame_word(4097, 1000, -1000, 25));
      seq.push_back(frame_word(0, -1000, 1000, 60));
      seq.push_back(tick_word());
      seq.push_back(tick_word());
      seq.push_back(frame_word(8191, -32768, 32767, 0));
      seq.push_back(frame_word(0, 32767, -32768, 255));
      seq.push_back(frame_word(5461, 12345, -12345, 170));
      seq.push_back(frame_word(2730, -21846, 21845, 85));
      seq.push_back(tick_word());
      seq.push_back(frame_word(8191, 0, 0, 0));
      seq.push_back(frame_word(4094, 0, 0, 0));
      seq.push_back(tick_word());
      seq.push_back(tick_word());
      foreach (seq[i]) begin
         send_word(seq[i]);
         pace_sender();
      end

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            case (p)
               1: begin angle_val = 32'hFFFF_FFFF; speed_val = 32'hFFFF_FFFF; end
               2: begin angle_val = 32'h0; speed_val = 32'h0; end
               3: begin angle_val = $urandom; speed_val = $urandom; end
               4: begin angle_val = 32'h1; speed_val = 32'h8000_0000; end
               5: begin angle_val = $urandom_range(0, 32'h00FF_FFFF); speed_val = $urandom; end
               default: begin angle_val = ANGLE_SCALE_RST; speed_val = SPEED_SCALE_RST; end
            endcase
            write_scale(REG_ANGLE_SCALE, angle_val);
            write_scale(REG_SPEED_SCALE, speed_val);
         end
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            send_word(random_word());
            pace_sender();
         end
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while (sb.pending() != 0) @(posedge clock);
      end

      repeat (16) @(posedge clock);
      $display("Checked %0d responses from %0d frames and %0d ticks over %0d scale settings",
               sb.checked, sb.frames, sb.ticks, PHASES);
      $display("Turn crossings: %0d, saturated scaled values: %0d",
               sb.turn_events, sb.saturated);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Timeout with %0d responses outstanding", sb.pending());
      $display("Mismatches found");
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/mftc_pkg.sv
rtl/core/mftc_chan_if.sv
rtl/core/mftc_front.sv
rtl/core/mftc_fifo.sv
rtl/core/mftc_back.sv
rtl/core/motor_feedback_multiturn_tracker_core.sv
verif/testbench.sv
